@@ rtl/bqc_pkg.sv @@
// bqc_pkg: shared types and codes of the biquad cascade filter
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package bqc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 20;
  localparam int STATE_W  = 40;
  localparam int PROD_W   = 36;
  localparam int ACC_W    = 42;
  localparam int SLOTS    = 5;

  typedef logic        [1:0]          cmd_t;
  typedef logic        [2:0]          slot_t;
  typedef logic        [2:0]          nsec_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // commands
  localparam cmd_t CMD_FILTER = 2'd0;
  localparam cmd_t CMD_WRITE  = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  // coefficient slots within a section
  localparam slot_t SLOT_B0 = 3'd0;
  localparam slot_t SLOT_B1 = 3'd1;
  localparam slot_t SLOT_B2 = 3'd2;
  localparam slot_t SLOT_A1 = 3'd3;
  localparam slot_t SLOT_A2 = 3'd4;

  // saturation bounds
  localparam acc_t STATE_MAX = acc_t'(64'sd549755813887);
  localparam acc_t STATE_MIN = acc_t'(-64'sd549755813888);
  localparam logic signed [25:0] OUT_MAX = 26'sd32767;
  localparam logic signed [25:0] OUT_MIN = -26'sd32768;

endpackage

@@ rtl/bqc_in_if.sv @@
// bqc_in_if: command channel of the biquad cascade filter
// depends on bqc_pkg for payload types
`timescale 1ns / 1ps

interface bqc_in_if;
  logic             valid;
  logic             ready;
  bqc_pkg::cmd_t    cmd;
  bqc_pkg::sample_t sample_in;
  logic [1:0]       coef_section;
  bqc_pkg::slot_t   coef_slot;
  bqc_pkg::coef_t   coef_value;

  modport source(output valid, cmd, sample_in, coef_section, coef_slot, coef_value,
                 input ready);
  modport sink(input valid, cmd, sample_in, coef_section, coef_slot, coef_value,
               output ready);
endinterface

@@ rtl/bqc_out_if.sv @@
// bqc_out_if: result channel of the biquad cascade filter
// depends on bqc_pkg for payload types
`timescale 1ns / 1ps

interface bqc_out_if;
  logic             valid;
  logic             ready;
  bqc_pkg::sample_t sample_out;
  logic             clipped;

  modport source(output valid, sample_out, clipped, input ready);
  modport sink(input valid, sample_out, clipped, output ready);
endinterface

@@ rtl/biquad_cascade_filter_top.sv @@
// a filter beat runs states P0, Y, Z1A, Z1B, Z2A, Z2B per active section, then
//   DONE, which waits for a free output register; with no active sections it goes to DONE
// one filter beat at a time: a new command is taken only in IDLE; the beat uses the single
//   shared multiplier and the one coefficient read port (five products per section)
// coefficient writes and clears give no result
// reset (rst, synchronous): coefficients and delay states read as zero,
//   active_sections is 1, both channels empty
// depends on bqc_pkg, bqc_in_if and bqc_out_if
`timescale 1ns / 1ps

module biquad_cascade_filter_top #(
  parameter int SECTIONS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  bqc_pkg::nsec_t      cfg_wr_data,
  bqc_in_if.sink              in_ch,
  bqc_out_if.source           out_ch
);

  localparam int COEFS = SECTIONS * bqc_pkg::SLOTS;
  localparam int CA_W  = $clog2(COEFS);
  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CNT_W = $clog2(SECTIONS + 1);

  // sequencer: one state per multiply of a section, plus one that writes z2 and steps on
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_P0   = 8'b0000_0010,  // b0*x
    S_Y    = 8'b0000_0100,  // y = round(b0*x + z1), b1*x
    S_Z1A  = 8'b0000_1000,  // b1*x + z2, a1*y
    S_Z1B  = 8'b0001_0000,  // z1 written, b2*x
    S_Z2A  = 8'b0010_0000,  // a2*y
    S_Z2B  = 8'b0100_0000,  // z2 written, next section
    S_DONE = 8'b1000_0000   // result into output register
  } seq_t;

  seq_t state;

  // configuration
  bqc_pkg::nsec_t active_sections;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sections <= 3'd1;
    end else if (cfg_wr_en) begin
      active_sections <= cfg_wr_data;
    end
  end

  logic [CNT_W-1:0] n_start;
  assign n_start = (int'(active_sections) > SECTIONS) ? CNT_W'(SECTIONS)
                                                      : CNT_W'(active_sections);

  logic in_acc;
  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // working registers
  logic [SEC_W-1:0] sec;
  logic [CA_W-1:0]  base;
  logic [CNT_W-1:0] n_eff;
  bqc_pkg::sample_t x;
  bqc_pkg::sample_t y;
  bqc_pkg::prod_t   prod;
  bqc_pkg::acc_t    acc;
  logic             clip;

  logic last;
  assign last = (CNT_W'(sec) + CNT_W'(1)) == n_eff;

  // coefficient store: one write and one read port, valid bit per entry
  bqc_pkg::coef_t   coef_mem [COEFS];
  logic [COEFS-1:0] coef_vld;
  logic [CA_W-1:0]  coef_raddr;
  logic [CA_W-1:0]  coef_waddr;
  logic             coef_we;
  bqc_pkg::coef_t   coef_rd;
  logic             coef_rd_vld;
  bqc_pkg::coef_t   coef_val;

  assign coef_we = in_acc && (in_ch.cmd == bqc_pkg::CMD_WRITE)
                   && (int'(in_ch.coef_section) < SECTIONS)
                   && (in_ch.coef_slot <= bqc_pkg::SLOT_A2);
  assign coef_waddr = CA_W'(int'(in_ch.coef_section) * bqc_pkg::SLOTS
                            + int'(in_ch.coef_slot));

  always_comb begin
    case (state)
      S_P0:    coef_raddr = base + CA_W'(bqc_pkg::SLOT_B1);
      S_Y:     coef_raddr = base + CA_W'(bqc_pkg::SLOT_A1);
      S_Z1A:   coef_raddr = base + CA_W'(bqc_pkg::SLOT_B2);
      S_Z1B:   coef_raddr = base + CA_W'(bqc_pkg::SLOT_A2);
      S_Z2B:   coef_raddr = last ? CA_W'(bqc_pkg::SLOT_B0) : base + CA_W'(bqc_pkg::SLOTS);
      default: coef_raddr = CA_W'(bqc_pkg::SLOT_B0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_ch.coef_value;
    end
    coef_rd     <= coef_mem[coef_raddr];
    coef_rd_vld <= coef_vld[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (coef_we) begin
      coef_vld[coef_waddr] <= 1'b1;
    end
  end

  assign coef_val = coef_rd_vld ? coef_rd : '0;

  // delay state stores, one entry per section; a clear drops the valid bits
  bqc_pkg::state_t     d1_mem [SECTIONS];
  bqc_pkg::state_t     d2_mem [SECTIONS];
  logic [SECTIONS-1:0] d1_vld;
  logic [SECTIONS-1:0] d2_vld;
  logic [SEC_W-1:0]    d_raddr;
  bqc_pkg::state_t     d1_rd;
  bqc_pkg::state_t     d2_rd;
  logic                d1_rd_vld;
  logic                d2_rd_vld;
  bqc_pkg::acc_t       d1_val;
  bqc_pkg::acc_t       d2_val;
  logic                d1_we;
  logic                d2_we;
  logic                clr;

  // next section's states are fetched while the current one finishes;
  // its own entries are written only after they were read
  always_comb begin
    case (state)
      S_IDLE:  d_raddr = '0;
      S_Z2B:   d_raddr = last ? '0 : SEC_W'(sec + SEC_W'(1));
      default: d_raddr = sec;
    endcase
  end

  assign clr   = in_acc && (in_ch.cmd == bqc_pkg::CMD_CLEAR);
  assign d1_we = (state == S_Z1B);
  assign d2_we = (state == S_Z2B);

  // saturated new states
  bqc_pkg::acc_t   z_sum;
  bqc_pkg::state_t z_sat;
  logic            z_clip;

  assign z_sum = acc - bqc_pkg::acc_t'(prod);

  always_comb begin
    if (z_sum > bqc_pkg::STATE_MAX) begin
      z_sat  = bqc_pkg::STATE_MAX[bqc_pkg::STATE_W-1:0];
      z_clip = 1'b1;
    end else if (z_sum < bqc_pkg::STATE_MIN) begin
      z_sat  = bqc_pkg::STATE_MIN[bqc_pkg::STATE_W-1:0];
      z_clip = 1'b1;
    end else begin
      z_sat  = z_sum[bqc_pkg::STATE_W-1:0];
      z_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (d1_we) begin
      d1_mem[sec] <= z_sat;
    end
    if (d2_we) begin
      d2_mem[sec] <= z_sat;
    end
    d1_rd     <= d1_mem[d_raddr];
    d2_rd     <= d2_mem[d_raddr];
    d1_rd_vld <= d1_vld[d_raddr];
    d2_rd_vld <= d2_vld[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      d1_vld <= '0;
      d2_vld <= '0;
    end else begin
      if (d1_we) begin
        d1_vld[sec] <= 1'b1;
      end
      if (d2_we) begin
        d2_vld[sec] <= 1'b1;
      end
    end
  end

  assign d1_val = d1_rd_vld ? bqc_pkg::acc_t'(d1_rd) : '0;
  assign d2_val = d2_rd_vld ? bqc_pkg::acc_t'(d2_rd) : '0;

  // shared multiplier: coefficient times section input or section output
  bqc_pkg::sample_t mul_opnd;
  bqc_pkg::prod_t   mul;

  assign mul_opnd = ((state == S_Z1A) || (state == S_Z2A)) ? y : x;
  assign mul      = bqc_pkg::prod_t'(coef_val) * bqc_pkg::prod_t'(mul_opnd);

  // section output: add half an lsb, floor to q1.15, saturate
  bqc_pkg::acc_t      y_sum;
  logic signed [25:0] y_q;
  bqc_pkg::sample_t   y_sat;
  logic               y_clip;

  assign y_sum = bqc_pkg::acc_t'(prod) + d1_val + bqc_pkg::acc_t'(32768);
  assign y_q   = y_sum[bqc_pkg::ACC_W-1:16];

  always_comb begin
    if (y_q > bqc_pkg::OUT_MAX) begin
      y_sat  = bqc_pkg::OUT_MAX[15:0];
      y_clip = 1'b1;
    end else if (y_q < bqc_pkg::OUT_MIN) begin
      y_sat  = bqc_pkg::OUT_MIN[15:0];
      y_clip = 1'b1;
    end else begin
      y_sat  = y_q[15:0];
      y_clip = 1'b0;
    end
  end

  // output register
  logic out_load;
  assign out_load = (state == S_DONE) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.sample_out <= x;
      out_ch.clipped    <= clip;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && (in_ch.cmd == bqc_pkg::CMD_FILTER)) begin
            state <= (n_start == '0) ? S_DONE : S_P0;
          end
        end
        S_P0:  state <= S_Y;
        S_Y:   state <= S_Z1A;
        S_Z1A: state <= S_Z1B;
        S_Z1B: state <= S_Z2A;
        S_Z2A: state <= S_Z2B;
        S_Z2B: state <= last ? S_DONE : S_P0;
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc && (in_ch.cmd == bqc_pkg::CMD_FILTER)) begin
          x     <= in_ch.sample_in;
          clip  <= 1'b0;
          sec   <= '0;
          base  <= '0;
          n_eff <= n_start;
        end
      end
      S_P0: begin
        prod <= mul;
      end
      S_Y: begin
        y    <= y_sat;
        clip <= clip | y_clip;
        prod <= mul;
      end
      S_Z1A: begin
        acc  <= bqc_pkg::acc_t'(prod) + d2_val;
        prod <= mul;
      end
      S_Z1B: begin
        clip <= clip | z_clip;
        acc  <= '0;
        prod <= mul;
      end
      S_Z2A: begin
        acc  <= bqc_pkg::acc_t'(prod);
        prod <= mul;
      end
      S_Z2B: begin
        clip <= clip | z_clip;
        x    <= y;
        if (!last) begin
          sec  <= SEC_W'(sec + SEC_W'(1));
          base <= base + CA_W'(bqc_pkg::SLOTS);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  // a filter beat with sections to run starts the first section next cycle
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_ch.cmd == bqc_pkg::CMD_FILTER) && (n_start != '0)) |=> (state == S_P0))
    else $error("filter beat did not start the section sequence");

  // the section counter stays below the active count while sections run
  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    ((state != S_IDLE) && (state != S_DONE)) |-> (CNT_W'(sec) < n_eff))
    else $error("section counter ran past the active sections");

  // a new result appears only from the completion state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state == S_DONE))
    else $error("result raised outside completion");

  // a clear leaves every delay state reading as zero
  a_clear: assert property (@(posedge clk) disable iff (rst)
    clr |=> ((d1_vld == '0) && (d2_vld == '0)))
    else $error("clear left delay states valid");
`endif

endmodule
